FILE: rtl/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants for the switchable stack/queue unit.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int unsigned DepthDef = 1024;
  localparam int unsigned WordW    = 64;
  localparam int unsigned DepthW   = 11;

  typedef enum logic [1:0] {
    KindPush    = 2'd0,
    KindPop     = 2'd1,
    KindFlip    = 2'd2,
    KindSetMode = 2'd3
  } kind_e;

  typedef enum logic {
    StIdle = 1'b0,
    StOut  = 1'b1
  } state_e;

  typedef struct packed {
    logic exec;
    logic wr_en;
    logic rd_en;
    logic pop_head;
    logic flip;
    logic set_mode;
    logic ok;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic mode;
  } stat_t;

endpackage

FILE: rtl/ssq_ctrl.sv
// ----------------------------------------------------------------------------
// ssq_ctrl
// Handshake controller: accepts items, decodes the operation and issues
// datapath commands, holds the result until it is taken.
// ----------------------------------------------------------------------------
module ssq_ctrl
  import ssq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  kind_e  kind;
  logic   free;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    kind    = kind_e'(kind_i);
    free    = (state_q == StIdle) || !out_stall_i;
    accept  = in_valid_i && free;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = accept ? StOut : StIdle;
      end
      default: state_d = StIdle;
    endcase

    cmd_o          = '0;
    cmd_o.exec     = accept;
    cmd_o.wr_en    = accept && (kind == KindPush) && !stat_i.full;
    cmd_o.rd_en    = accept && (kind == KindPop) && !stat_i.empty;
    cmd_o.pop_head = stat_i.mode;
    cmd_o.flip     = accept && (kind == KindFlip);
    cmd_o.set_mode = accept && (kind == KindSetMode);
    cmd_o.ok       = cmd_o.wr_en || cmd_o.rd_en;

    in_stall_o  = !free;
    out_valid_o = (state_q == StOut);
  end

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("accepted item produced no result");

  a_held_result_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd_o.exec)
    else $error("item executed while result still pending");

  a_stalled_result_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

FILE: rtl/ssq_dpath.sv
// ----------------------------------------------------------------------------
// ssq_dpath
// Datapath: circular word store, fill count, base pointer, direction and
// mode registers, slot address arithmetic and result registers.
// ----------------------------------------------------------------------------
module ssq_dpath
  import ssq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [WordW-1:0]  push_word_i,
  input  logic              new_mode_i,
  output stat_t             stat_o,
  output logic [WordW-1:0]  popped_word_o,
  output logic              success_o,
  output logic [DepthW-1:0] depth_after_o,
  output logic              mode_after_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]    DepthA = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0]  DepthC = CW'(DEPTH);
  localparam logic [AW-1:0]  LastSlot = AW'(DEPTH - 1);

  logic [WordW-1:0] store_q [DEPTH];
  logic [WordW-1:0] rd_q;

  logic [CW-1:0] cnt_q, cnt_d, cnt_m1;
  logic [AW-1:0] base_q, base_d;
  logic          rev_q, rev_d;
  logic          mode_q, mode_d;
  logic          pv_q, ok_q;

  logic [AW-1:0] pos, slot, fwd_slot, rvs_slot, base_inc, base_dec, rd_addr;
  logic [AW:0]   fwd, rvs;

  always_comb begin
    cnt_m1   = cnt_q - 1'b1;
    pos      = cmd_i.wr_en ? cnt_q[AW-1:0] : cnt_m1[AW-1:0];
    fwd      = {1'b0, base_q} + {1'b0, pos};
    fwd_slot = (fwd >= DepthA) ? AW'(fwd - DepthA) : fwd[AW-1:0];
    rvs      = {1'b0, base_q} - {1'b0, pos};
    rvs_slot = rvs[AW] ? AW'(rvs + DepthA) : rvs[AW-1:0];
    slot     = rev_q ? rvs_slot : fwd_slot;
    base_inc = (base_q == LastSlot) ? '0 : base_q + 1'b1;
    base_dec = (base_q == '0) ? LastSlot : base_q - 1'b1;
    rd_addr  = cmd_i.pop_head ? base_q : slot;

    cnt_d  = cnt_q;
    base_d = base_q;
    rev_d  = rev_q;
    mode_d = mode_q;
    if (cmd_i.wr_en) cnt_d = cnt_q + 1'b1;
    if (cmd_i.rd_en) begin
      cnt_d = cnt_m1;
      if (cmd_i.pop_head) base_d = rev_q ? base_dec : base_inc;
    end
    if (cmd_i.flip) begin
      if (cnt_q != '0) base_d = slot;
      rev_d  = !rev_q;
      mode_d = !mode_q;
    end
    if (cmd_i.set_mode) mode_d = new_mode_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) store_q[slot] <= push_word_i;
    if (cmd_i.rd_en) rd_q <= store_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      base_q <= '0;
      rev_q  <= 1'b0;
      mode_q <= 1'b0;
      pv_q   <= 1'b0;
      ok_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      base_q <= base_d;
      rev_q  <= rev_d;
      mode_q <= mode_d;
      if (cmd_i.exec) begin
        pv_q <= cmd_i.rd_en;
        ok_q <= cmd_i.ok;
      end
    end
  end

  assign stat_o.empty  = (cnt_q == '0);
  assign stat_o.full   = (cnt_q == DepthC);
  assign stat_o.mode   = mode_q;
  assign popped_word_o = pv_q ? rd_q : '0;
  assign success_o     = ok_q;
  assign depth_after_o = DepthW'(cnt_q);
  assign mode_after_o  = mode_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("fill count beyond capacity");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not advance fill count");

  a_tail_pop_keeps_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_en && !cmd_i.pop_head) |=> $stable(base_q))
    else $error("tail pop moved the base pointer");

endmodule

FILE: rtl/switchable_stack_queue_unit.sv
// ----------------------------------------------------------------------------
// switchable_stack_queue_unit
// Buffer of up to DEPTH 64-bit words that acts as a stack (lifo) or a queue
// (fifo), with push, pop, flip (reverse order and toggle mode) and set mode.
// ----------------------------------------------------------------------------
// Each item yields one result in the cycle after it is accepted; a new item is
// taken in the same cycle the previous result is taken, so the unit sustains
// one item per cycle when the output is not stalled. The single word store is
// written by push and read by pop at the accept edge, its registered read
// data forming the popped word. A push to a full buffer and a pop from an
// empty one fail with success low and a zero word. The store needs no clear
// after reset.
module switchable_stack_queue_unit
  import ssq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic [WordW-1:0]  push_word_i,
  input  logic              new_mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WordW-1:0]  popped_word_o,
  output logic              success_o,
  output logic [DepthW-1:0] depth_after_o,
  output logic              mode_after_o
);

  cmd_t  cmd;
  stat_t stat;

  ssq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ssq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .push_word_i   (push_word_i),
    .new_mode_i    (new_mode_i),
    .stat_o        (stat),
    .popped_word_o (popped_word_o),
    .success_o     (success_o),
    .depth_after_o (depth_after_o),
    .mode_after_o  (mode_after_o)
  );

endmodule
